// ===== hw/rtl/rx_fifo_with_event_triggers_macros.svh =====
// ----------------------------------------------------------------------------
// Receive FIFO assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RX_FIFO_WITH_EVENT_TRIGGERS_MACROS_SVH
`define RX_FIFO_WITH_EVENT_TRIGGERS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFET_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rfet_pkg.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO package
// Operation codes, register indexes, field widths and the result record.
// ----------------------------------------------------------------------------
package rfet_pkg;

	localparam int BYTE_W = 8;
	localparam int MODE_W = 2;
	localparam int FILL_W = 6;
	localparam int THR_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_RX    = 2'd0,
		MODE_POP   = 2'd1,
		MODE_PEEK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TERM_ENABLE    = 2'd0,
		CFG_TERM_CHAR      = 2'd1,
		CFG_SIZE_ENABLE    = 2'd2,
		CFG_SIZE_THRESHOLD = 2'd3
	} cfg_idx_t;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 6'd1;

	typedef struct packed {
		logic              read_valid;
		logic [FILL_W-1:0] fill_count;
		logic              event_res;
		logic              overrun;
	} result_t;

endpackage

// ===== hw/rtl/rfet_if.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfet_in_if;
	logic                         valid;
	logic                         ready;
	logic [rfet_pkg::MODE_W-1:0]  mode;
	logic [rfet_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface rfet_out_if;
	logic                         valid;
	logic                         ready;
	logic [rfet_pkg::BYTE_W-1:0]  read_byte;
	logic                         read_valid;
	logic [rfet_pkg::FILL_W-1:0]  fill_count;
	logic                         event_res;
	logic                         overrun;

	modport source (output valid, output read_byte, output read_valid,
		output fill_count, output event_res, output overrun, input ready);
	modport sink (input valid, input read_byte, input read_valid,
		input fill_count, input event_res, input overrun, output ready);
endinterface

// ===== hw/rtl/rx_fifo_with_event_triggers.sv =====
// Timing: a result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register stalls the
// request side only while a result waits and the response side is not ready.
// Reset: pointers and fill count clear, registers return to their reset
// values, and the byte store keeps undefined contents with no clearing pass.
// ----------------------------------------------------------------------------
// Receive FIFO with event triggers
// Byte ring buffer with pop, peek, clear, overrun flag and receive event.
// ----------------------------------------------------------------------------
module rx_fifo_with_event_triggers #(
	parameter int RX_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rfet_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rfet_pkg::CFG_DATA_W-1:0] cfg_data,
	rfet_in_if.sink                         cmd,
	rfet_out_if.source                      rsp
);

	localparam int PTR_W = $clog2(RX_DEPTH);

	logic                        accept;
	logic                        in_ready;
	logic                        mem_we;
	logic [PTR_W-1:0]            mem_waddr, mem_raddr;
	logic [rfet_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;
	rfet_pkg::result_t           res;

	assign cmd.ready = in_ready;
	assign accept    = cmd.valid && in_ready;

	rfet_ctrl #(
		.RX_DEPTH (RX_DEPTH),
		.PTR_W    (PTR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.mode      (cmd.mode),
		.rx_byte   (cmd.rx_byte),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	rfet_store #(
		.DEPTH (RX_DEPTH),
		.AW    (PTR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rfet_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res_d    (res),
		.rdata    (mem_rdata),
		.in_ready (in_ready),
		.rsp      (rsp)
	);

endmodule

// ===== hw/rtl/rfet_store.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO byte store
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module rfet_store #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [rfet_pkg::BYTE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [rfet_pkg::BYTE_W-1:0] rdata
);

	logic [rfet_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [rfet_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read data is held until the next read so that a stalled result keeps it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/rfet_ctrl.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO control
// Configuration registers, ring pointers, fill count and event decision.
// ----------------------------------------------------------------------------
`include "rx_fifo_with_event_triggers_macros.svh"

module rfet_ctrl #(
	parameter int RX_DEPTH = 64,
	parameter int PTR_W = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rfet_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfet_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           accept,
	input  logic [rfet_pkg::MODE_W-1:0]    mode,
	input  logic [rfet_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           mem_we,
	output logic [PTR_W-1:0]               mem_waddr,
	output logic [rfet_pkg::BYTE_W-1:0]    mem_wdata,
	output logic [PTR_W-1:0]               mem_raddr,
	output rfet_pkg::result_t              res
);

	localparam int CMP_W = (PTR_W > rfet_pkg::THR_W) ? PTR_W : rfet_pkg::THR_W;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(RX_DEPTH - 1);

	logic                          term_enable_q;
	logic [rfet_pkg::BYTE_W-1:0]   term_char_q;
	logic                          size_enable_q;
	logic [rfet_pkg::THR_W-1:0]    size_threshold_q;

	logic [PTR_W-1:0] wr_q, rd_q, fill_q;
	logic [PTR_W-1:0] wr_d, rd_d, fill_d;
	logic [PTR_W-1:0] fill_inc;
	logic [CMP_W-1:0] fill_ext, inc_ext, thr_ext;
	logic             full, empty, store_ok, ev;
	logic [PTR_W-1:0] ptr_dist;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == LAST) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_enable_q    <= 1'b0;
			term_char_q      <= '0;
			size_enable_q    <= 1'b0;
			size_threshold_q <= rfet_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (rfet_pkg::cfg_idx_t'(cfg_index))
				rfet_pkg::CFG_TERM_ENABLE: begin
					term_enable_q <= cfg_data[0];
				end
				rfet_pkg::CFG_TERM_CHAR: begin
					term_char_q <= cfg_data;
				end
				rfet_pkg::CFG_SIZE_ENABLE: begin
					size_enable_q <= cfg_data[0];
				end
				rfet_pkg::CFG_SIZE_THRESHOLD: begin
					size_threshold_q <= cfg_data[rfet_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign full     = (fill_q == LAST);
	assign empty    = (fill_q == '0);
	assign fill_inc = PTR_W'(fill_q + 1'b1);
	assign inc_ext  = CMP_W'(fill_inc);
	assign thr_ext  = CMP_W'(size_threshold_q);

	// The size trigger has priority; with it alone enabled, a byte below the
	// threshold raises nothing, and with no trigger enabled every byte does.
	always_comb begin
		if (size_enable_q && (inc_ext >= thr_ext)) begin
			ev = 1'b1;
		end else if (size_enable_q && !term_enable_q) begin
			ev = 1'b0;
		end else if (term_enable_q) begin
			ev = (rx_byte == term_char_q);
		end else begin
			ev = 1'b1;
		end
	end

	always_comb begin
		wr_d           = wr_q;
		rd_d           = rd_q;
		fill_d         = fill_q;
		store_ok       = 1'b0;
		res.read_valid = 1'b0;
		res.event_res  = 1'b0;
		res.overrun    = 1'b0;
		case (rfet_pkg::mode_t'(mode))
			rfet_pkg::MODE_RX: begin
				if (full) begin
					res.overrun = 1'b1;
				end else begin
					store_ok      = 1'b1;
					wr_d          = ring_next(wr_q);
					fill_d        = fill_inc;
					res.event_res = ev;
				end
			end
			rfet_pkg::MODE_POP: begin
				if (!empty) begin
					res.read_valid = 1'b1;
					rd_d           = ring_next(rd_q);
					fill_d         = PTR_W'(fill_q - 1'b1);
				end
			end
			rfet_pkg::MODE_PEEK: begin
				res.read_valid = !empty;
			end
			rfet_pkg::MODE_CLEAR: begin
				rd_d   = wr_q;
				fill_d = '0;
			end
			default: begin
			end
		endcase
		fill_ext       = CMP_W'(fill_d);
		res.fill_count = fill_ext[rfet_pkg::FILL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wr_q   <= wr_d;
			rd_q   <= rd_d;
			fill_q <= fill_d;
		end
	end

	assign mem_we    = accept && store_ok;
	assign mem_waddr = wr_q;
	assign mem_wdata = rx_byte;
	assign mem_raddr = rd_q;

	assign ptr_dist = (wr_q >= rd_q) ? PTR_W'(wr_q - rd_q)
		: PTR_W'(RX_DEPTH + int'(wr_q) - int'(rd_q));

	`RFET_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= LAST, "fill count beyond capacity")
	`RFET_ASSERT_SAME(a_fill_dist, 1'b1, fill_q == ptr_dist, "fill count and pointers disagree")
	`RFET_ASSERT_NEXT(a_clear_empty, accept && (mode == rfet_pkg::MODE_CLEAR),
		fill_q == '0 && rd_q == wr_q, "clear left bytes behind")
	`RFET_ASSERT_NEXT(a_overrun_hold, accept && res.overrun,
		$stable(wr_q) && $stable(fill_q), "dropped byte changed the state")

endmodule

// ===== hw/rtl/rfet_out_reg.sv =====
// ----------------------------------------------------------------------------
// Receive FIFO result register
// Holds one result until the response channel takes it.
// ----------------------------------------------------------------------------
module rfet_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  rfet_pkg::result_t           res_d,
	input  logic [rfet_pkg::BYTE_W-1:0] rdata,
	output logic                        in_ready,
	rfet_out_if.source                  rsp
);

	logic              valid_q;
	rfet_pkg::result_t res_s1;

	// A new request is taken whenever the result slot is empty or drains this cycle.
	assign in_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res_d;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.read_byte  = res_s1.read_valid ? rdata : '0;
	assign rsp.read_valid = res_s1.read_valid;
	assign rsp.fill_count = res_s1.fill_count;
	assign rsp.event_res  = res_s1.event_res;
	assign rsp.overrun    = res_s1.overrun;

endmodule
